// ===== src/stpr_pkg.sv =====
// Shared types, codes and constants for the stepper tray positioner.
// Used by stpr_core and the top level through scoped names.
package stpr_pkg;

  // Motor geometry
  localparam int unsigned StepsPerRev = 200;
  localparam int unsigned HalfRev     = StepsPerRev / 2;

  // Item operation codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_MOVE = 2'd1;
  localparam logic [1:0] OP_HOME = 2'd2;

  // Controller modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_MOVING = 2'd1;
  localparam logic [1:0] MODE_HOMING = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_POS_CLASS0 = 3'd0;
  localparam logic [2:0] CFG_POS_CLASS1 = 3'd1;
  localparam logic [2:0] CFG_POS_CLASS2 = 3'd2;
  localparam logic [2:0] CFG_POS_CLASS3 = 3'd3;
  localparam logic [2:0] CFG_SLOW_DELAY = 3'd4;
  localparam logic [2:0] CFG_FAST_DELAY = 3'd5;
  localparam logic [2:0] CFG_RAMP_LEN   = 3'd6;

  // Item classes with a dedicated position register
  localparam logic [2:0] CLASS_ALU   = 3'd0;
  localparam logic [2:0] CLASS_STEEL = 3'd1;
  localparam logic [2:0] CLASS_WHITE = 3'd2;

  typedef struct packed {
    logic [7:0] pos_class0;
    logic [7:0] pos_class1;
    logic [7:0] pos_class2;
    logic [7:0] pos_class3;
    logic [7:0] slow_delay;
    logic [7:0] fast_delay;
    logic [7:0] ramp_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0] phase_index;
    logic [7:0] position;
    logic [7:0] target;
    logic [7:0] steps_togo;
    logic [7:0] steps_total;
    logic [7:0] step_delay;
    logic [7:0] wait_count;
    logic       direction_ccw;
    logic [1:0] mode;
  } state_t;

  // Full-step coil drive table
  function automatic logic [5:0] coil_of(logic [1:0] phase);
    logic [5:0] pat;
    case (phase)
      2'd0:    pat = 6'h36;
      2'd1:    pat = 6'h2E;
      2'd2:    pat = 6'h2D;
      default: pat = 6'h35;
    endcase
    return pat;
  endfunction

endpackage

// ===== src/stepper_tray_positioner_with_ramp_top.sv =====
// Top level of the stepper tray positioner: input register, state, result register.
// Depends on stpr_pkg and stpr_core.
//
// Each transaction on the input channel (a 1 ms tick, a move request or a homing
// request) yields exactly one result transaction carrying the coil pattern, busy
// flag, tray position, direction and an ignored-request flag after that item.
// The block takes one item per clock cycle when the output side keeps up: an item
// is held in the input register, and the state update and result register load
// happen together when it advances, which waits while a stalled result is held.
// The state update is a single pass of short logic. Configuration writes are
// accepted at any time (ready is tied high) and must only be issued while the
// block is idle; indexes beyond 6 are dropped.
module stepper_tray_positioner_with_ramp_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [2:0] item_class_i,
  input  logic       hall_seen_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [5:0] coil_pattern_o,
  output logic       busy_res_o,
  output logic [7:0] tray_position_o,
  output logic       moving_ccw_o,
  output logic       request_ignored_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  stpr_pkg::cfg_t   cfg_q;
  stpr_pkg::state_t st_q;
  stpr_pkg::state_t st_d;
  logic             ignored;

  logic             s1_valid_q;
  logic [1:0]       s1_op_q;
  logic [2:0]       s1_class_q;
  logic             s1_hall_q;
  logic             out_valid_q;
  logic             advance;

  // Handshake: advance when a result slot is free or being taken
  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_class0 <= 8'd50;
      cfg_q.pos_class1 <= 8'd150;
      cfg_q.pos_class2 <= 8'd100;
      cfg_q.pos_class3 <= 8'd0;
      cfg_q.slow_delay <= 8'd14;
      cfg_q.fast_delay <= 8'd5;
      cfg_q.ramp_len   <= 8'd9;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        stpr_pkg::CFG_POS_CLASS0: cfg_q.pos_class0 <= cfg_data_i;
        stpr_pkg::CFG_POS_CLASS1: cfg_q.pos_class1 <= cfg_data_i;
        stpr_pkg::CFG_POS_CLASS2: cfg_q.pos_class2 <= cfg_data_i;
        stpr_pkg::CFG_POS_CLASS3: cfg_q.pos_class3 <= cfg_data_i;
        stpr_pkg::CFG_SLOW_DELAY: cfg_q.slow_delay <= cfg_data_i;
        stpr_pkg::CFG_FAST_DELAY: cfg_q.fast_delay <= cfg_data_i;
        stpr_pkg::CFG_RAMP_LEN:   cfg_q.ramp_len   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: hold one transaction until the update stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q    <= op_i;
      s1_class_q <= item_class_i;
      s1_hall_q  <= hall_seen_i;
    end
  end

  stpr_core u_core (
    .cur_i        (st_q),
    .cfg_i        (cfg_q),
    .op_i         (s1_op_q),
    .item_class_i (s1_class_q),
    .hall_seen_i  (s1_hall_q),
    .nxt_o        (st_d),
    .ignored_o    (ignored)
  );

  // Controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase_index   <= 2'd0;
      st_q.position      <= 8'd0;
      st_q.target        <= 8'd0;
      st_q.steps_togo    <= 8'd0;
      st_q.steps_total   <= 8'd0;
      st_q.step_delay    <= 8'd0;
      st_q.wait_count    <= 8'd0;
      st_q.direction_ccw <= 1'b0;
      st_q.mode          <= stpr_pkg::MODE_IDLE;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      coil_pattern_o    <= stpr_pkg::coil_of(st_d.phase_index);
      busy_res_o        <= (st_d.mode != stpr_pkg::MODE_IDLE);
      tray_position_o   <= st_d.position;
      moving_ccw_o      <= st_d.direction_ccw;
      request_ignored_o <= ignored;
    end
  end

endmodule

// ===== src/stpr_core.sv =====
// Next-state logic of the tray positioner: one item applied to the current state.
// Depends on stpr_pkg for state, configuration types and codes.
module stpr_core (
  input  stpr_pkg::state_t cur_i,
  input  stpr_pkg::cfg_t   cfg_i,
  input  logic [1:0]       op_i,
  input  logic [2:0]       item_class_i,
  input  logic             hall_seen_i,
  output stpr_pkg::state_t nxt_o,
  output logic             ignored_o
);

  logic [7:0] pos_raw;
  logic [7:0] tgt;
  logic [7:0] diff;
  logic [7:0] path_len;
  logic       dir_raw;
  logic       dir_ccw;
  logic [7:0] done_steps;
  logic [7:0] delay_dn;
  logic [7:0] delay_up;
  logic [7:0] left_dec;

  // Look up the class target and fold it into one revolution
  always_comb begin
    case (item_class_i)
      stpr_pkg::CLASS_ALU:   pos_raw = cfg_i.pos_class0;
      stpr_pkg::CLASS_STEEL: pos_raw = cfg_i.pos_class1;
      stpr_pkg::CLASS_WHITE: pos_raw = cfg_i.pos_class2;
      default:               pos_raw = cfg_i.pos_class3;
    endcase
    tgt = (pos_raw >= 8'(stpr_pkg::StepsPerRev)) ?
          pos_raw - 8'(stpr_pkg::StepsPerRev) : pos_raw;
  end

  // Pick the shorter way round
  always_comb begin
    dir_raw = (tgt < cur_i.position);
    diff    = dir_raw ? cur_i.position - tgt : tgt - cur_i.position;
    if (diff > 8'(stpr_pkg::HalfRev)) begin
      path_len = 8'(stpr_pkg::StepsPerRev) - diff;
      dir_ccw  = !dir_raw;
    end else begin
      path_len = diff;
      dir_ccw  = dir_raw;
    end
  end

  // Trapezoidal ramp: drop during the first steps, rise during the last
  always_comb begin
    done_steps = cur_i.steps_total - cur_i.steps_togo;
    delay_dn   = (cur_i.step_delay > cfg_i.fast_delay && done_steps < cfg_i.ramp_len) ?
                 cur_i.step_delay - 8'd1 : cur_i.step_delay;
    delay_up   = (delay_dn < cfg_i.slow_delay && cur_i.steps_togo < cfg_i.ramp_len) ?
                 delay_dn + 8'd1 : delay_dn;
    left_dec   = (cur_i.steps_togo != 8'd0) ? cur_i.steps_togo - 8'd1 : cur_i.steps_togo;
  end

  // Apply the transaction to the state
  always_comb begin
    nxt_o     = cur_i;
    ignored_o = 1'b0;
    case (op_i)
      stpr_pkg::OP_TICK: begin
        if (cur_i.mode != stpr_pkg::MODE_IDLE) begin
          if (cur_i.wait_count > 8'd1) begin
            nxt_o.wait_count = cur_i.wait_count - 8'd1;
          end else if (cur_i.mode == stpr_pkg::MODE_HOMING) begin
            if (hall_seen_i) begin
              nxt_o.position   = 8'd0;
              nxt_o.mode       = stpr_pkg::MODE_IDLE;
              nxt_o.wait_count = 8'd0;
            end else begin
              nxt_o.phase_index = cur_i.phase_index + 2'd1;
              nxt_o.wait_count  = cfg_i.slow_delay;
            end
          end else begin
            nxt_o.step_delay = delay_up;
            nxt_o.steps_togo = left_dec;
            if (left_dec == 8'd0) begin
              nxt_o.position   = cur_i.target;
              nxt_o.mode       = stpr_pkg::MODE_IDLE;
              nxt_o.wait_count = 8'd0;
            end else begin
              nxt_o.phase_index = cur_i.direction_ccw ? cur_i.phase_index - 2'd1 :
                                                        cur_i.phase_index + 2'd1;
              nxt_o.wait_count  = delay_up;
            end
          end
        end
      end
      stpr_pkg::OP_MOVE: begin
        if (cur_i.mode != stpr_pkg::MODE_IDLE) begin
          ignored_o = 1'b1;
        end else begin
          nxt_o.target        = tgt;
          nxt_o.direction_ccw = dir_ccw;
          if (path_len == 8'd0) begin
            nxt_o.position = tgt;
          end else begin
            nxt_o.steps_total = path_len;
            nxt_o.steps_togo  = path_len;
            nxt_o.step_delay  = cfg_i.slow_delay;
            nxt_o.mode        = stpr_pkg::MODE_MOVING;
            nxt_o.phase_index = dir_ccw ? cur_i.phase_index - 2'd1 :
                                          cur_i.phase_index + 2'd1;
            nxt_o.wait_count  = cfg_i.slow_delay;
          end
        end
      end
      stpr_pkg::OP_HOME: begin
        if (cur_i.mode != stpr_pkg::MODE_IDLE) begin
          ignored_o = 1'b1;
        end else begin
          nxt_o.direction_ccw = 1'b0;
          if (hall_seen_i) begin
            nxt_o.position = 8'd0;
          end else begin
            nxt_o.mode        = stpr_pkg::MODE_HOMING;
            nxt_o.phase_index = cur_i.phase_index + 2'd1;
            nxt_o.wait_count  = cfg_i.slow_delay;
          end
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

// ===== src/stpr_checker.sv =====
// Port-level checks for the stepper tray positioner top level.
// Bound to stepper_tray_positioner_with_ramp_top; no package dependency.
module stpr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [5:0] coil_pattern_o,
  input logic       busy_res_o,
  input logic [7:0] tray_position_o,
  input logic       moving_ccw_o,
  input logic       request_ignored_o
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(coil_pattern_o) &&
      $stable(tray_position_o) && $stable(busy_res_o) && $stable(moving_ccw_o) &&
      $stable(request_ignored_o))
    else $error("stalled result changed");

  // Drop a request only while a move or homing runs
  a_ignored_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && request_ignored_o |-> busy_res_o)
    else $error("request ignored while idle");

  // Drive only table patterns on the coils
  a_coil_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (coil_pattern_o == 6'h36 || coil_pattern_o == 6'h2E ||
                     coil_pattern_o == 6'h2D || coil_pattern_o == 6'h35))
    else $error("coil pattern outside phase table");

  // Keep the position within one revolution
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tray_position_o < 8'd200)
    else $error("tray position out of range");

endmodule

bind stepper_tray_positioner_with_ramp_top stpr_checker u_stpr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .coil_pattern_o    (coil_pattern_o),
  .busy_res_o        (busy_res_o),
  .tray_position_o   (tray_position_o),
  .moving_ccw_o      (moving_ccw_o),
  .request_ignored_o (request_ignored_o)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the stepper tray positioner with step-delay ramp.
// Depends on stpr_pkg and stepper_tray_positioner_with_ramp_top, which uses stpr_core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes this bench needs beyond the package
  localparam logic [1:0] OP_NONE    = 2'd3;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int DIR_ROWS    = 23;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic [5:0] coil;
    logic       busy;
    logic [7:0] pos;
    logic       ccw;
    logic       ignored;
  } tray_result_t;

  typedef struct packed {
    logic [1:0]   op;
    logic [2:0]   cls;
    logic         hall;
    logic         typed;
    tray_result_t res;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [1:0] op_i = stpr_pkg::OP_TICK;
  logic [2:0] item_class_i = 3'd0;
  logic       hall_seen_i = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = 3'd0;
  logic [7:0] cfg_data_i = 8'd0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [5:0] coil_pattern_o;
  logic       busy_res_o;
  logic [7:0] tray_position_o;
  logic       moving_ccw_o;
  logic       request_ignored_o;
  logic       cfg_ready_o;

  // Tracked copy of the block's settings and motion state
  logic [7:0] class_pos [4];
  logic [7:0] slow_dly;
  logic [7:0] fast_dly;
  logic [7:0] ramp_steps;
  logic [1:0] coil_phase = 2'd0;
  logic [7:0] tray_pos = 8'd0;
  logic [7:0] goal_pos = 8'd0;
  logic [7:0] steps_rem = 8'd0;
  logic [7:0] steps_all = 8'd0;
  logic [7:0] cur_dly = 8'd0;
  logic [7:0] wait_cnt = 8'd0;
  logic       dir_ccw = 1'b0;
  logic [1:0] tray_mode = stpr_pkg::MODE_IDLE;

  tray_result_t pending_results [$];
  stim_row_t    directed_rows [DIR_ROWS];
  int           send_idle_pct = 11;
  int           recv_stall_pct = 72;
  bit           failed = 1'b0;

  stepper_tray_positioner_with_ramp_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .item_class_i      (item_class_i),
    .hall_seen_i       (hall_seen_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .coil_pattern_o    (coil_pattern_o),
    .busy_res_o        (busy_res_o),
    .tray_position_o   (tray_position_o),
    .moving_ccw_o      (moving_ccw_o),
    .request_ignored_o (request_ignored_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [5:0] coil_for_phase(input logic [1:0] ph);
    case (ph)
      2'd0:    return 6'h36;
      2'd1:    return 6'h2E;
      2'd2:    return 6'h2D;
      default: return 6'h35;
    endcase
  endfunction

  // Advance one full step; the 2-bit phase wraps on its own
  function automatic void turn_phase(input logic ccw);
    coil_phase = ccw ? coil_phase - 2'd1 : coil_phase + 2'd1;
  endfunction

  // Apply one item to the tracked state and return the result it produces
  function automatic tray_result_t track_tray(input logic [1:0] op, input logic [2:0] cls,
                                              input logic hall);
    tray_result_t res;
    logic         ignored;
    logic [7:0]   dest;
    logic [7:0]   done_steps;
    logic         ccw;
    int           span;
    ignored = 1'b0;
    if (op == stpr_pkg::OP_TICK) begin
      if (tray_mode == stpr_pkg::MODE_IDLE) begin
        // idle ticks change nothing
      end else if (wait_cnt > 8'd1) begin
        wait_cnt = wait_cnt - 8'd1;
      end else if (tray_mode == stpr_pkg::MODE_HOMING) begin
        if (hall) begin
          tray_pos = 8'd0;
          tray_mode = stpr_pkg::MODE_IDLE;
          wait_cnt = 8'd0;
        end else begin
          turn_phase(1'b0);
          wait_cnt = slow_dly;
        end
      end else begin
        // end of a step: accelerate early, decelerate late
        done_steps = steps_all - steps_rem;
        if (cur_dly > fast_dly && done_steps < ramp_steps) cur_dly = cur_dly - 8'd1;
        if (cur_dly < slow_dly && steps_rem < ramp_steps) cur_dly = cur_dly + 8'd1;
        if (steps_rem > 8'd0) steps_rem = steps_rem - 8'd1;
        if (steps_rem == 8'd0) begin
          tray_pos = goal_pos;
          tray_mode = stpr_pkg::MODE_IDLE;
          wait_cnt = 8'd0;
        end else begin
          turn_phase(dir_ccw);
          wait_cnt = cur_dly;
        end
      end
    end else if (op == stpr_pkg::OP_MOVE || op == stpr_pkg::OP_HOME) begin
      if (tray_mode != stpr_pkg::MODE_IDLE) begin
        ignored = 1'b1;
      end else if (op == stpr_pkg::OP_MOVE) begin
        dest = (cls > stpr_pkg::CLASS_WHITE) ? class_pos[3] : class_pos[cls[1:0]];
        if (dest >= 8'(stpr_pkg::StepsPerRev)) dest = dest - 8'(stpr_pkg::StepsPerRev);
        ccw = (dest < tray_pos);
        span = ccw ? int'(tray_pos) - int'(dest) : int'(dest) - int'(tray_pos);
        // take the shorter way round
        if (span > int'(stpr_pkg::HalfRev)) begin
          span = int'(stpr_pkg::StepsPerRev) - span;
          ccw = !ccw;
        end
        goal_pos = dest;
        dir_ccw = ccw;
        if (span == 0) begin
          tray_pos = goal_pos;
        end else begin
          steps_all = 8'(span);
          steps_rem = 8'(span);
          cur_dly = slow_dly;
          tray_mode = stpr_pkg::MODE_MOVING;
          turn_phase(ccw);
          wait_cnt = cur_dly;
        end
      end else begin
        dir_ccw = 1'b0;
        if (hall) begin
          tray_pos = 8'd0;
        end else begin
          tray_mode = stpr_pkg::MODE_HOMING;
          turn_phase(1'b0);
          wait_cnt = slow_dly;
        end
      end
    end
    res.coil = coil_for_phase(coil_phase);
    res.busy = (tray_mode != stpr_pkg::MODE_IDLE);
    res.pos = tray_pos;
    res.ccw = dir_ccw;
    res.ignored = ignored;
    return res;
  endfunction

  // Present one item, hold it until taken, then record what it should produce
  task automatic offer_item(input logic [1:0] op, input logic [2:0] cls, input logic hall,
                            input logic typed, input tray_result_t typed_res);
    tray_result_t predicted;
    in_valid_i <= 1'b1;
    op_i <= op;
    item_class_i <= cls;
    hall_seen_i <= hall;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = track_tray(op, cls, hall);
    pending_results.push_back(typed ? typed_res : predicted);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      stpr_pkg::CFG_POS_CLASS0: class_pos[0] = val;
      stpr_pkg::CFG_POS_CLASS1: class_pos[1] = val;
      stpr_pkg::CFG_POS_CLASS2: class_pos[2] = val;
      stpr_pkg::CFG_POS_CLASS3: class_pos[3] = val;
      stpr_pkg::CFG_SLOW_DELAY: slow_dly = val;
      stpr_pkg::CFG_FAST_DELAY: fast_dly = val;
      stpr_pkg::CFG_RAMP_LEN:   ramp_steps = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [7:0] p0, input logic [7:0] p1,
                               input logic [7:0] p2, input logic [7:0] p3,
                               input logic [7:0] slow, input logic [7:0] fast,
                               input logic [7:0] ramp);
    write_reg(stpr_pkg::CFG_POS_CLASS0, p0);
    write_reg(stpr_pkg::CFG_POS_CLASS1, p1);
    write_reg(stpr_pkg::CFG_POS_CLASS2, p2);
    write_reg(stpr_pkg::CFG_POS_CLASS3, p3);
    write_reg(stpr_pkg::CFG_SLOW_DELAY, slow);
    write_reg(stpr_pkg::CFG_FAST_DELAY, fast);
    write_reg(stpr_pkg::CFG_RAMP_LEN, ramp);
    cfg_valid_i <= 1'b0;
  endtask

  // Finish any motion, then let the pipeline empty before touching registers
  task automatic wait_idle();
    while (tray_mode != stpr_pkg::MODE_IDLE)
      offer_item(stpr_pkg::OP_TICK, 3'($urandom_range(7)), 1'b1, 1'b0, '0);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly requests when idle and ticks when busy, with some stray requests and op 3
  task automatic pick_item(output logic [1:0] op, output logic [2:0] cls, output logic hall);
    int roll;
    roll = $urandom_range(99);
    cls = 3'($urandom_range(7));
    hall = ($urandom_range(9) == 0);
    if (tray_mode == stpr_pkg::MODE_IDLE) begin
      if (roll < 45) op = stpr_pkg::OP_MOVE;
      else if (roll < 65) op = stpr_pkg::OP_HOME;
      else if (roll < 92) op = stpr_pkg::OP_TICK;
      else op = OP_NONE;
    end else begin
      if (roll < 90) op = stpr_pkg::OP_TICK;
      else if (roll < 94) op = stpr_pkg::OP_MOVE;
      else if (roll < 97) op = stpr_pkg::OP_HOME;
      else op = OP_NONE;
      // let homing find the magnet after a few steps
      if (tray_mode == stpr_pkg::MODE_HOMING && wait_cnt <= 8'd1)
        hall = ($urandom_range(3) == 0);
    end
  endtask

  // Check every result transaction against the oldest expectation
  initial begin : result_monitor
    tray_result_t want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: coil %h busy %b pos %0d", coil_pattern_o, busy_res_o,
                 tray_position_o);
          failed = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (coil_pattern_o !== want.coil) begin
            $error("coil_pattern: expected %h, got %h", want.coil, coil_pattern_o);
            failed = 1'b1;
          end
          if (busy_res_o !== want.busy) begin
            $error("busy_res: expected %b, got %b", want.busy, busy_res_o);
            failed = 1'b1;
          end
          if (tray_position_o !== want.pos) begin
            $error("tray_position: expected %0d, got %0d", want.pos, tray_position_o);
            failed = 1'b1;
          end
          if (moving_ccw_o !== want.ccw) begin
            $error("moving_ccw: expected %b, got %b", want.ccw, moving_ccw_o);
            failed = 1'b1;
          end
          if (request_ignored_o !== want.ignored) begin
            $error("request_ignored: expected %b, got %b", want.ignored, request_ignored_o);
            failed = 1'b1;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    int         row;
    int         ph;
    int         n;
    logic [1:0] op;
    logic [2:0] cls;
    logic       hall;
    // register values after reset
    class_pos[0] = 8'd50;
    class_pos[1] = 8'd150;
    class_pos[2] = 8'd100;
    class_pos[3] = 8'd0;
    slow_dly = 8'd14;
    fast_dly = 8'd5;
    ramp_steps = 8'd9;
    // op, class, hall, typed, then coil/busy/position/ccw/ignored where typed
    directed_rows = '{
      // straight out of reset: tick, unused op, homing with the magnet in view
      {stpr_pkg::OP_TICK, 3'd0, 1'b0, 1'b1, 6'h36, 1'b0, 8'd0, 1'b0, 1'b0},
      {OP_NONE, 3'd7, 1'b1, 1'b1, 6'h36, 1'b0, 8'd0, 1'b0, 1'b0},
      {stpr_pkg::OP_HOME, 3'd5, 1'b1, 1'b1, 6'h36, 1'b0, 8'd0, 1'b0, 1'b0},
      // one-step move, then requests while busy
      {stpr_pkg::OP_MOVE, stpr_pkg::CLASS_ALU, 1'b0, 1'b0, 17'd0},
      {stpr_pkg::OP_MOVE, stpr_pkg::CLASS_STEEL, 1'b1, 1'b1, 6'h2E, 1'b1, 8'd0, 1'b0, 1'b1},
      {stpr_pkg::OP_HOME, stpr_pkg::CLASS_ALU, 1'b1, 1'b1, 6'h2E, 1'b1, 8'd0, 1'b0, 1'b1},
      {stpr_pkg::OP_TICK, 3'd0, 1'b0, 1'b0, 17'd0},
      // invalid class whose wrapped target is already reached
      {stpr_pkg::OP_MOVE, 3'd4, 1'b0, 1'b0, 17'd0},
      // wrap-around moves both ways
      {stpr_pkg::OP_MOVE, stpr_pkg::CLASS_STEEL, 1'b0, 1'b0, 17'd0},
      {stpr_pkg::OP_TICK, 3'd1, 1'b0, 1'b0, 17'd0},
      {stpr_pkg::OP_TICK, 3'd2, 1'b1, 1'b0, 17'd0},
      {stpr_pkg::OP_MOVE, stpr_pkg::CLASS_ALU, 1'b0, 1'b0, 17'd0},
      {stpr_pkg::OP_TICK, 3'd3, 1'b0, 1'b0, 17'd0},
      {stpr_pkg::OP_TICK, 3'd4, 1'b0, 1'b0, 17'd0},
      // homing that steps until the magnet shows up
      {stpr_pkg::OP_HOME, 3'd6, 1'b0, 1'b0, 17'd0},
      {stpr_pkg::OP_TICK, 3'd0, 1'b0, 1'b0, 17'd0},
      {stpr_pkg::OP_TICK, 3'd0, 1'b1, 1'b0, 17'd0},
      {stpr_pkg::OP_MOVE, 3'd7, 1'b0, 1'b0, 17'd0},
      {stpr_pkg::OP_TICK, 3'd5, 1'b1, 1'b0, 17'd0},
      {OP_NONE, stpr_pkg::CLASS_WHITE, 1'b0, 1'b0, 17'd0},
      {stpr_pkg::OP_TICK, 3'd0, 1'b0, 1'b0, 17'd0},
      {stpr_pkg::OP_MOVE, stpr_pkg::CLASS_WHITE, 1'b0, 1'b0, 17'd0},
      {stpr_pkg::OP_TICK, 3'd0, 1'b0, 1'b0, 17'd0}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < 3; row++)
      offer_item(directed_rows[row].op, directed_rows[row].cls, directed_rows[row].hall,
                 directed_rows[row].typed, directed_rows[row].res);
    // short moves with one-tick steps; class 3 target above one revolution
    wait_idle();
    write_reg(CFG_UNUSED, 8'hFF);
    load_settings(8'd1, 8'd199, 8'd0, 8'd201, 8'd1, 8'd1, 8'd0);
    for (row = 3; row < DIR_ROWS; row++)
      offer_item(directed_rows[row].op, directed_rows[row].cls, directed_rows[row].hall,
                 directed_rows[row].typed, directed_rows[row].res);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        // zero delay, fast above slow, half-turn tie, out-of-range target
        0: load_settings(8'd0, 8'd100, 8'd199, 8'd255, 8'd0, 8'd200, 8'd0);
        1: load_settings(8'd10, 8'd20, 8'd30, 8'd200, 8'd3, 8'd1, 8'd2);
        // top fast delay and ramp, nearby targets keep the moves short
        2: load_settings(8'd0, 8'd1, 8'd2, 8'd199, 8'd12, 8'd255, 8'd255);
        3: load_settings(8'd50, 8'd150, 8'd100, 8'd0, 8'd6, 8'd2, 8'd4);
        // ramp longer than any move: both rules fire on every step
        4: load_settings(8'd5, 8'd105, 8'd55, 8'd155, 8'd4, 8'd2, 8'd255);
        default: load_settings(8'd3, 8'd7, 8'd197, 8'd193, 8'd8, 8'd3, 8'd3);
      endcase
      if (ph < 2) begin
        send_idle_pct = 11;
        recv_stall_pct = 72;
      end else if (ph < 4) begin
        send_idle_pct = 72;
        recv_stall_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick_item(op, cls, hall);
        offer_item(op, cls, hall, 1'b0, '0);
      end
    end

    // drain and give stray results time to show up
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (!failed) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/stpr_pkg.sv
src/stpr_core.sv
src/stepper_tray_positioner_with_ramp_top.sv
src/stpr_checker.sv
tb/sv/tb_top.sv
